// ===== sv/ctw_pkg.sv =====
// ----------------------------------------------------------------------------
// ctw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package ctw_pkg;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE      = 8'd10;
  localparam logic [15:0] BLANK_CELL        = 16'h0F20;
  localparam logic [15:0] SCROLL_FILL_RESET = 16'd15;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [3:0] color;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

endpackage

// ===== sv/ctw_in_if.sv =====
// ----------------------------------------------------------------------------
// ctw_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface ctw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic [3:0] color;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, mode, char_code, color, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_code, color, read_row, read_col, output ready);
endinterface

// ===== sv/ctw_out_if.sv =====
// ----------------------------------------------------------------------------
// ctw_out_if
// Output channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface ctw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_offset;
  logic [15:0] cell_value;
  logic        scrolled;

  modport source (output valid, cursor_offset, cell_value, scrolled, input ready);
  modport sink   (input valid, cursor_offset, cell_value, scrolled, output ready);
endinterface

// ===== sv/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console writer: put-char, newline, scroll, clear and cell read over a
// ROWS x COLS store of 16-bit cell words.
// ----------------------------------------------------------------------------
// put-char, newline, no-op: back end passes S_IDLE, S_DONE; read: S_READ too
// scroll: each row below the top is copied up via S_SCR_RD/S_SCR_WR, then the
// bottom row is filled (S_FILL); clear: ROWS*COLS cells blanked in S_CLEAR;
// front register and queue lie ahead; after reset the store is swept to blank;
// words are queued meanwhile and executed once the sweep is done
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ctw_in_if.sink      in_i,
  ctw_out_if.source   out_o
);

  logic [15:0]   fill_q;
  logic          push_valid, push_ready;
  ctw_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  ctw_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= ctw_pkg::SCROLL_FILL_RESET;
    end else if (cfg_we_i) begin
      fill_q <= cfg_wdata_i;
    end
  end

  ctw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  ctw_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  ctw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scroll_fill_i (fill_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_cmd_i     (pop_cmd),
    .out_o         (out_o)
  );

endmodule

// ===== sv/ctw_front.sv =====
// ----------------------------------------------------------------------------
// ctw_front
// Accepts input words and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module ctw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ctw_in_if.sink         in_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output ctw_pkg::cmd_t  push_cmd_o
);

  logic          valid_q, valid_d;
  ctw_pkg::cmd_t cmd_q, cmd_d;
  ctw_pkg::op_e  op;

  assign in_i.ready   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_cmd_o   = cmd_q;

  always_comb begin
    case (in_i.mode)
      ctw_pkg::MODE_PUT: begin
        op = (in_i.char_code == ctw_pkg::NEWLINE_CODE) ? ctw_pkg::OP_NEWLINE
                                                       : ctw_pkg::OP_PUT;
      end
      ctw_pkg::MODE_CLEAR: begin
        op = ctw_pkg::OP_CLEAR;
      end
      ctw_pkg::MODE_READ: begin
        // out-of-range reads behave as no-ops
        op = (int'(in_i.read_row) < ROWS && int'(in_i.read_col) < COLS)
             ? ctw_pkg::OP_READ : ctw_pkg::OP_NOP;
      end
      default: begin
        op = ctw_pkg::OP_NOP;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (in_i.valid && in_i.ready) begin
      valid_d         = 1'b1;
      cmd_d.op        = op;
      cmd_d.char_code = in_i.char_code;
      cmd_d.color     = in_i.color;
      cmd_d.read_row  = in_i.read_row;
      cmd_d.read_col  = in_i.read_col;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ===== sv/ctw_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ctw_cmd_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module ctw_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ctw_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ctw_pkg::cmd_t pop_cmd_o
);

  ctw_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/ctw_back.sv =====
// ----------------------------------------------------------------------------
// ctw_back
// Executes commands on the cell store, keeps the cursor, returns results.
// ----------------------------------------------------------------------------
module ctw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   scroll_fill_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  ctw_pkg::cmd_t pop_cmd_i,
  ctw_out_if.source     out_o
);

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(COLS);
  localparam int RW     = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_ADDR = AW'(NCELLS - 1);
  localparam logic [AW-1:0] LAST_ROW  = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_RROW = RW'(ROWS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCR_RD = 3'd3;
  localparam logic [2:0] S_SCR_WR = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_CLEAR  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [15:0]   mem [NCELLS];
  logic [15:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [15:0]   cell_q, cell_d;
  logic          scr_q, scr_d;
  logic          out_valid_q, out_valid_d;
  logic [10:0]   out_off_q, out_off_d;
  logic [15:0]   out_cell_q, out_cell_d;
  logic          out_scr_q, out_scr_d;
  logic          slot_free;
  logic [AW-1:0] rd_addr;

  assign pop_ready_o         = (state_q == S_IDLE);
  assign slot_free           = !out_valid_q || out_o.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.cursor_offset = out_off_q;
  assign out_o.cell_value    = out_cell_q;
  assign out_o.scrolled      = out_scr_q;
  assign rd_addr = AW'(int'(pop_cmd_i.read_row) * COLS + int'(pop_cmd_i.read_col));

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    col_d       = col_q;
    row_d       = row_q;
    cur_d       = cur_q;
    cell_d      = cell_q;
    scr_d       = scr_q;
    out_valid_d = out_valid_q;
    out_off_d   = out_off_q;
    out_cell_d  = out_cell_q;
    out_scr_d   = out_scr_q;
    we          = 1'b0;
    waddr       = ptr_q;
    wdata       = ctw_pkg::BLANK_CELL;
    raddr       = ptr_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        we = 1'b1;
        if (ptr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (pop_valid_i) begin
          cell_d  = '0;
          scr_d   = 1'b0;
          state_d = S_DONE;
          case (pop_cmd_i.op)
            ctw_pkg::OP_PUT, ctw_pkg::OP_NEWLINE: begin
              if (pop_cmd_i.op == ctw_pkg::OP_PUT) begin
                we    = 1'b1;
                waddr = cur_q;
                wdata = {4'b0, pop_cmd_i.color, pop_cmd_i.char_code};
              end
              if (pop_cmd_i.op == ctw_pkg::OP_PUT && col_q != LAST_COL) begin
                col_d = col_q + 1'b1;
                cur_d = cur_q + 1'b1;
              end else if (row_q == LAST_RROW) begin
                // leaving the bottom row: scroll up one row
                col_d   = '0;
                cur_d   = LAST_ROW;
                scr_d   = 1'b1;
                ptr_d   = COLS_A;
                state_d = S_SCR_RD;
              end else begin
                col_d = '0;
                row_d = row_q + 1'b1;
                cur_d = cur_q + COLS_A - AW'(col_q);
              end
            end
            ctw_pkg::OP_CLEAR: begin
              ptr_d   = '0;
              state_d = S_CLEAR;
            end
            ctw_pkg::OP_READ: begin
              raddr   = rd_addr;
              state_d = S_READ;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        cell_d  = rdata_q;
        state_d = S_DONE;
      end
      S_SCR_RD: begin
        state_d = S_SCR_WR;
      end
      S_SCR_WR: begin
        we    = 1'b1;
        waddr = ptr_q - COLS_A;
        wdata = rdata_q;
        if (ptr_q == LAST_ADDR) begin
          ptr_d   = LAST_ROW;
          state_d = S_FILL;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_SCR_RD;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        wdata = scroll_fill_i;
        if (ptr_q == LAST_ADDR) begin
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        if (ptr_q == LAST_ADDR) begin
          col_d   = '0;
          row_d   = '0;
          cur_d   = '0;
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_off_d   = 11'(cur_q);
          out_cell_d  = cell_q;
          out_scr_d   = scr_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q     <= cell_d;
    scr_q      <= scr_d;
    out_off_q  <= out_off_d;
    out_cell_q <= out_cell_d;
    out_scr_q  <= out_scr_d;
  end

  // cell store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule
